// ----- src/lattice_spin_flip_metropolis_macros.svh -----
// ----------------------------------------------------------------------------
// lattice spin flip metropolis - assertion macros
// shared concurrent checks on clk with reset rst_n
// ----------------------------------------------------------------------------
`ifndef LATTICE_SPIN_FLIP_METROPOLIS_MACROS_SVH
`define LATTICE_SPIN_FLIP_METROPOLIS_MACROS_SVH

// consequent in the same cycle
`define LSFM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the next cycle
`define LSFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lsfm_pkg.sv -----
// ----------------------------------------------------------------------------
// lsfm_pkg
// widths, reset values and codes of the ising metropolis engine
// ----------------------------------------------------------------------------
package lsfm_pkg;

  localparam int LATTICE_SIDE = 64;
  localparam int SIDE_W       = $clog2(LATTICE_SIDE);

  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int RND_W      = 16;
  localparam int FIELD_W    = 15;
  localparam int ENERGY_W   = 15;
  localparam int MAG_W      = 14;
  localparam int THR_W      = 16;
  localparam int CFG_DATA_W = 64;
  localparam int THR_LOW_W  = 64;
  localparam int THR_MID_W  = 64;
  localparam int THR_HIGH_W = 32;

  localparam logic [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * LATTICE_SIDE * LATTICE_SIDE);
  localparam logic [MAG_W-1:0]    MAG_RESET    = MAG_W'(LATTICE_SIDE * LATTICE_SIDE);

  typedef logic [LATTICE_SIDE-1:0] row_t;

  typedef enum logic {
    OP_ATTEMPT = 1'b0,
    OP_FORCE   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_FIELD    = 2'd0,
    CFG_THR_LOW  = 2'd1,
    CFG_THR_MID  = 2'd2,
    CFG_THR_HIGH = 2'd3
  } cfg_idx_t;

endpackage

// ----- src/lsfm_in_if.sv -----
// ----------------------------------------------------------------------------
// lsfm_in_if
// request channel: site, operation, random value and forced spin
// ----------------------------------------------------------------------------
interface lsfm_in_if;
  logic                           valid;
  logic                           ready;
  lsfm_pkg::op_t                  operation;
  logic [lsfm_pkg::ROW_W-1:0]     row;
  logic [lsfm_pkg::COL_W-1:0]     column;
  logic [lsfm_pkg::RND_W-1:0]     random_value;
  logic                           spin_value;

  modport source (output valid, operation, row, column, random_value, spin_value,
                  input ready);
  modport sink   (input valid, operation, row, column, random_value, spin_value,
                  output ready);
endinterface

// ----- src/lsfm_out_if.sv -----
// ----------------------------------------------------------------------------
// lsfm_out_if
// result channel: flip flag, site spin and running totals
// ----------------------------------------------------------------------------
interface lsfm_out_if;
  logic                                valid;
  logic                                ready;
  logic                                accepted;
  logic                                site_spin;
  logic signed [lsfm_pkg::ENERGY_W-1:0] bond_energy;
  logic signed [lsfm_pkg::MAG_W-1:0]    magnetization;

  modport source (output valid, accepted, site_spin, bond_energy, magnetization,
                  input ready);
  modport sink   (input valid, accepted, site_spin, bond_energy, magnetization,
                  output ready);
endinterface

// ----- src/lattice_spin_flip_metropolis.sv -----
// ----------------------------------------------------------------------------
// lattice_spin_flip_metropolis - ising metropolis single spin flip engine
// pipeline: neighbour rows read on both ports, then the centre row, then the result
//   registered and the row written back when the output register is free
// a new request is taken as the previous one leaves the compute stage, not during the reads
// reset: a clearing pass writes every lattice row to +1, no request taken meanwhile
// ----------------------------------------------------------------------------
`include "lattice_spin_flip_metropolis_macros.svh"

module lattice_spin_flip_metropolis (
  input  logic                                 clk,
  input  logic                                 rst_n,
  lsfm_in_if.sink                              in_chan,
  lsfm_out_if.source                           out_chan,
  input  logic                                 cfg_we,
  input  lsfm_pkg::cfg_idx_t                   cfg_index,
  input  logic [lsfm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // configuration
  logic signed [lsfm_pkg::FIELD_W-1:0]  field_r;
  logic [lsfm_pkg::THR_LOW_W-1:0]       thr_low_r;
  logic [lsfm_pkg::THR_MID_W-1:0]       thr_mid_r;
  logic [lsfm_pkg::THR_HIGH_W-1:0]      thr_high_r;

  // row store
  lsfm_pkg::row_t                       spin_mem [lsfm_pkg::LATTICE_SIDE];
  lsfm_pkg::row_t                       rd_a_r, rd_b_r;
  logic                                 rd_a_en, rd_b_en;
  logic [lsfm_pkg::SIDE_W-1:0]          rd_a_addr, rd_b_addr;
  logic                                 wr_en;
  logic [lsfm_pkg::SIDE_W-1:0]          wr_addr;
  lsfm_pkg::row_t                       wr_data;

  // clearing pass
  logic                                 clr_busy_r;
  logic [lsfm_pkg::SIDE_W-1:0]          clr_row_r;

  // pipeline control and request payload
  logic                                 s1_r, s2_r;
  logic                                 in_fire, s2_done;
  lsfm_pkg::op_t                        item_op_r;
  logic [lsfm_pkg::SIDE_W-1:0]          item_row_r, item_col_r;
  logic [lsfm_pkg::RND_W-1:0]           item_rnd_r;
  logic                                 item_want_r;
  logic [lsfm_pkg::SIDE_W-1:0]          in_row, up_addr, dn_addr;

  // forwarding of a row written on the same edge as the neighbour reads
  logic                                 fwd_up_r, fwd_dn_r;
  lsfm_pkg::row_t                       fwd_data_r;
  lsfm_pkg::row_t                       up_r, dn_r;

  // compute
  logic [lsfm_pkg::SIDE_W-1:0]          col_l, col_r;
  logic                                 s_cur;
  logic [2:0]                           n_pos;
  logic signed [4:0]                    nsum_s;
  logic signed [16:0]                   val_s;
  logic                                 de_le0;
  logic [3:0]                           k_case;
  logic [159:0]                         thr_all;
  logic [lsfm_pkg::THR_W-1:0]           thr_sel;
  logic                                 flip;
  lsfm_pkg::row_t                       new_row;
  logic signed [4:0]                    e_delta;
  logic signed [lsfm_pkg::ENERGY_W-1:0] energy_r, energy_nxt;
  logic signed [lsfm_pkg::MAG_W-1:0]    mag_r, mag_nxt;

  // output register
  logic                                 out_valid_r;
  logic                                 out_accepted_r;
  logic                                 out_spin_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_r    <= '0;
      thr_low_r  <= '0;
      thr_mid_r  <= '0;
      thr_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsfm_pkg::CFG_FIELD:    field_r    <= cfg_wdata[lsfm_pkg::FIELD_W-1:0];
        lsfm_pkg::CFG_THR_LOW:  thr_low_r  <= cfg_wdata[lsfm_pkg::THR_LOW_W-1:0];
        lsfm_pkg::CFG_THR_MID:  thr_mid_r  <= cfg_wdata[lsfm_pkg::THR_MID_W-1:0];
        lsfm_pkg::CFG_THR_HIGH: thr_high_r <= cfg_wdata[lsfm_pkg::THR_HIGH_W-1:0];
      endcase
    end
  end

  // handshake
  assign s2_done       = s2_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !clr_busy_r && !s1_r && (!s2_r || s2_done);
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign in_row  = lsfm_pkg::SIDE_W'(in_chan.row);
  assign up_addr = in_row - lsfm_pkg::SIDE_W'(1);
  assign dn_addr = in_row + lsfm_pkg::SIDE_W'(1);

  // memory ports
  assign rd_a_en   = in_fire || s1_r;
  assign rd_a_addr = s1_r ? item_row_r : up_addr;
  assign rd_b_en   = in_fire;
  assign rd_b_addr = dn_addr;
  assign wr_en     = clr_busy_r || (s2_done && flip);
  assign wr_addr   = clr_busy_r ? clr_row_r : item_row_r;
  assign wr_data   = clr_busy_r ? '1 : new_row;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      spin_mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_r <= spin_mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_r <= spin_mem[rd_b_addr];
    end
  end

  // clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_row_r  <= '0;
    end else if (clr_busy_r) begin
      clr_row_r <= clr_row_r + lsfm_pkg::SIDE_W'(1);
      if (clr_row_r == lsfm_pkg::SIDE_W'(lsfm_pkg::LATTICE_SIDE - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r        <= 1'b0;
      s2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_r <= in_fire;
      if (s1_r) begin
        s2_r <= 1'b1;
      end else if (s2_done) begin
        s2_r <= 1'b0;
      end
      if (s2_done) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_op_r   <= in_chan.operation;
      item_row_r  <= in_row;
      item_col_r  <= lsfm_pkg::SIDE_W'(in_chan.column);
      item_rnd_r  <= in_chan.random_value;
      item_want_r <= in_chan.spin_value;
      fwd_up_r    <= wr_en && (wr_addr == up_addr);
      fwd_dn_r    <= wr_en && (wr_addr == dn_addr);
      fwd_data_r  <= wr_data;
    end
    if (s1_r) begin
      up_r <= fwd_up_r ? fwd_data_r : rd_a_r;
      dn_r <= fwd_dn_r ? fwd_data_r : rd_b_r;
    end
    if (s2_done) begin
      out_accepted_r <= flip;
      out_spin_r     <= s_cur ^ flip;
    end
  end

  // energy change and acceptance
  assign col_l   = item_col_r - lsfm_pkg::SIDE_W'(1);
  assign col_r   = item_col_r + lsfm_pkg::SIDE_W'(1);
  assign s_cur   = rd_a_r[item_col_r];
  assign n_pos   = {2'b00, up_r[item_col_r]} + {2'b00, dn_r[item_col_r]}
                 + {2'b00, rd_a_r[col_l]} + {2'b00, rd_a_r[col_r]};
  assign nsum_s  = $signed({1'b0, n_pos, 1'b0}) - 5'sd4;
  assign val_s   = $signed({nsum_s, 12'b0})
                 + $signed({{2{field_r[lsfm_pkg::FIELD_W-1]}}, field_r});
  assign de_le0  = s_cur ? (val_s <= 17'sd0) : (val_s >= 17'sd0);
  assign k_case  = s_cur ? ({1'b0, n_pos} + 4'd5) : {1'b0, n_pos};
  assign thr_all = {thr_high_r, thr_mid_r, thr_low_r};
  assign thr_sel = thr_all[k_case * lsfm_pkg::THR_W +: lsfm_pkg::THR_W];

  always_comb begin
    if (item_op_r == lsfm_pkg::OP_FORCE) begin
      flip = (item_want_r != s_cur);
    end else begin
      flip = de_le0 || (item_rnd_r < thr_sel);
    end
  end

  assign new_row    = rd_a_r ^ (lsfm_pkg::row_t'(1) << item_col_r);
  assign e_delta    = s_cur ? $signed({nsum_s[3:0], 1'b0}) : -$signed({nsum_s[3:0], 1'b0});
  assign energy_nxt = energy_r + $signed({{(lsfm_pkg::ENERGY_W-5){e_delta[4]}}, e_delta});
  assign mag_nxt    = s_cur ? (mag_r - lsfm_pkg::MAG_W'(2)) : (mag_r + lsfm_pkg::MAG_W'(2));

  // running totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_r <= lsfm_pkg::ENERGY_RESET;
      mag_r    <= lsfm_pkg::MAG_RESET;
    end else if (s2_done && flip) begin
      energy_r <= energy_nxt;
      mag_r    <= mag_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.accepted      = out_accepted_r;
  assign out_chan.site_spin     = out_spin_r;
  assign out_chan.bond_energy   = energy_r;
  assign out_chan.magnetization = mag_r;

  `LSFM_ASSERT_NEXT(a_s1_moves, s1_r, s2_r, "request did not reach the compute stage")
  `LSFM_ASSERT_NOW(a_one_in_flight, s1_r, !s2_r, "two requests in flight")
  `LSFM_ASSERT_NOW(a_clear_idle, clr_busy_r, !s1_r && !s2_r, "request during clearing pass")
  `LSFM_ASSERT_NOW(a_totals_even, 1'b1, !mag_r[0] && !energy_r[0], "odd running total")

endmodule
